>>> sv/permutation_unrank_lexicographic_top_defines.svh
// ----------------------------------------------------------------------------
// Permutation unrank assertion macros
// Concurrent assertion wrappers on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_LEXICOGRAPHIC_TOP_DEFINES_SVH
`define PERMUTATION_UNRANK_LEXICOGRAPHIC_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset.
`define PUL_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define PUL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PUL_ASSERT(lbl, cond)
`define PUL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/pul_pkg.sv
// ----------------------------------------------------------------------------
// Permutation unrank package
// Fixed widths, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pul_pkg;

  localparam int RANK_W     = 16;  // rank field width
  localparam int DIV_BITS   = 8;   // quotient bits resolved per divide cycle
  localparam int FIELD_W    = 3;   // position and element field width
  localparam int CFG_W      = 4;   // perm_length register width
  localparam int LEN_RESET  = 8;   // perm_length after reset

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } pul_state_t;

  typedef struct packed {
    logic load;      // take a new rank, reset counters and pool
    logic div_step;  // resolve DIV_BITS quotient bits
    logic emit;      // pick one element into the output register
  } pul_cmd_t;

  typedef struct packed {
    logic div_end;   // current divide step finishes the last digit
    logic emit_end;  // current emit produces the last element
    logic out_free;  // output register can take a new element
  } pul_status_t;

endpackage

`default_nettype wire

>>> sv/permutation_unrank_lexicographic_top.sv
// ----------------------------------------------------------------------------
// Permutation unrank, lexicographic order
// Returns the permutation of 0..n-1 at a given rank, one element per transfer.
// ----------------------------------------------------------------------------
// A rank is taken in one transfer and answered by n result transfers in
// position order, the final one marked by out_last. The rank is reduced modulo
// n factorial. One rank is in work at a time: after acceptance the divider
// resolves 8 quotient bits per cycle of the 16-bit rank for each
// factorial-base digit, then one element is picked per cycle when the output
// is not stalled. The next rank is taken while the last element still waits
// in the output register.
// perm_length (0 reads as 1, values above MAX_LEN saturate) may be written at
// any cycle; cfg_ready is always high. Write it only while no item is open.
`default_nettype none

`include "permutation_unrank_lexicographic_top_defines.svh"

module permutation_unrank_lexicographic_top
  import pul_pkg::*;
#(
  parameter int MAX_LEN = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [RANK_W-1:0]  in_rank,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FIELD_W-1:0]      out_position,
  output logic [FIELD_W-1:0]      out_element,
  output logic                    out_last
);

  pul_cmd_t    cmd;
  pul_status_t status;

  assign cfg_ready = 1'b1;

  pul_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  pul_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .in_rank      (in_rank),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_element  (out_element),
    .out_last     (out_last)
  );

  `PUL_ASSERT(a_cmd_exclusive, $onehot0({cmd.load, cmd.div_step, cmd.emit}))
  `PUL_ASSERT(a_no_overwrite, !(cmd.emit && out_valid && out_stall))
  `PUL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

>>> sv/pul_ctrl.sv
// ----------------------------------------------------------------------------
// Permutation unrank controller
// Sequences load, digit extraction and element emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pul_ctrl
  import pul_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire pul_status_t status,
  output pul_cmd_t         cmd,
  output logic             in_stall
);

  pul_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_end) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/pul_dp.sv
// ----------------------------------------------------------------------------
// Permutation unrank datapath
// Factorial-base digit divider, digit store, element pool and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pul_dp
  import pul_pkg::*;
#(
  parameter int MAX_LEN = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pul_cmd_t           cmd,
  output pul_status_t             status,
  input  wire logic               cfg_valid,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic [RANK_W-1:0]  in_rank,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FIELD_W-1:0]      out_position,
  output logic [FIELD_W-1:0]      out_element,
  output logic                    out_last
);

  localparam int LW = $clog2(MAX_LEN + 1);  // holds a length 0..MAX_LEN
  localparam int IW = $clog2(MAX_LEN);      // holds an index 0..MAX_LEN-1
  localparam int RW = LW + 1;               // partial remainder during a divide
  localparam int LEN_INIT = (LEN_RESET > MAX_LEN) ? MAX_LEN : LEN_RESET;

  // effective length, clamped on write
  logic [LW-1:0] n_r;
  logic [LW-1:0] n_m1;
  logic [CFG_W-1:0] cfg_clamped;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (cfg_data > CFG_W'(MAX_LEN)) begin
      cfg_clamped = CFG_W'(MAX_LEN);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= LW'(LEN_INIT);
    end else if (cfg_valid) begin
      n_r <= LW'(cfg_clamped);
    end
  end

  assign n_m1 = n_r - LW'(1);

  // divider: radix j+1 for digit position n-1-j
  logic [RANK_W-1:0]   q_r;
  logic [LW-1:0]       rem_r;
  logic                half_r;
  logic [IW-1:0]       j_r;
  logic [LW-1:0]       radix;
  logic [RW-1:0]       rem_v;
  logic [DIV_BITS-1:0] qbits;
  logic [IW-1:0]       dig_idx;
  logic [IW-1:0]       dig_r [MAX_LEN];

  assign radix   = LW'(j_r) + LW'(1);
  assign dig_idx = IW'(n_m1 - LW'(j_r));

  always_comb begin
    rem_v = RW'(rem_r);
    qbits = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      rem_v = {rem_v[RW-2:0], q_r[RANK_W-1-b]};
      if (rem_v >= RW'(radix)) begin
        rem_v = rem_v - RW'(radix);
        qbits[DIV_BITS-1-b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r    <= in_rank;
      rem_r  <= '0;
      half_r <= 1'b0;
      j_r    <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[RANK_W-DIV_BITS-1:0], qbits};
      half_r <= ~half_r;
      if (half_r) begin
        // remainder is final: store the digit and move to the next radix
        dig_r[dig_idx] <= IW'(rem_v);
        rem_r <= '0;
        j_r   <= j_r + IW'(1);
      end else begin
        rem_r <= LW'(rem_v);
      end
    end
  end

  // pool of unused values, kept sorted and compacted
  logic [IW-1:0] p_r;
  logic [LW-1:0] rm_r;
  logic [IW-1:0] pool_r [MAX_LEN];
  logic [IW-1:0] d_raw;
  logic [IW-1:0] d_sel;
  logic [IW-1:0] pick;
  logic          out_valid_r;

  assign d_raw = dig_r[p_r];
  assign d_sel = (LW'(d_raw) >= rm_r) ? IW'(rm_r - LW'(1)) : d_raw;
  assign pick  = pool_r[d_sel];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r  <= '0;
      rm_r <= n_r;
      for (int k = 0; k < MAX_LEN; k++) begin
        pool_r[k] <= IW'(k);
      end
    end else if (cmd.emit) begin
      p_r  <= p_r + IW'(1);
      rm_r <= rm_r - LW'(1);
      // close the gap left by the picked value
      for (int k = 0; k < MAX_LEN - 1; k++) begin
        if (IW'(k) >= d_sel) pool_r[k] <= pool_r[k+1];
      end
    end
  end

  // output register
  logic [FIELD_W-1:0] out_position_r;
  logic [FIELD_W-1:0] out_element_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_position_r <= FIELD_W'(p_r);
      out_element_r  <= FIELD_W'(pick);
      out_last_r     <= (p_r == IW'(n_m1));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_element  = out_element_r;
  assign out_last     = out_last_r;

  assign status.div_end  = half_r && (j_r == IW'(n_m1));
  assign status.emit_end = (p_r == IW'(n_m1));
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire
